### hdl/pbc_pkg.sv
package pbc_pkg;

    localparam int INDEX_W = 8;
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 3 * CHAN_W;
    localparam int OP_W    = 2;
    localparam int LEVEL_W = 7;
    localparam int STEP_W  = 5;
    localparam int SUM_W   = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [OP_W-1:0] OP_WR_SRC = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_TGT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STEP = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd64;
    localparam int                 LEVEL_SHIFT = 6;
    localparam logic [STEP_W-1:0]  BLEND_FULL  = 5'd31;

    // x / 31 == (x * RECIP) >> RECIP_SHIFT for every x below 2^14
    localparam int              RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP    = 16'd33826;
    localparam int              RECIP_SHIFT = 20;
    localparam int              PROD_W      = SUM_W + RECIP_W;

    localparam logic MODE_SCALE     = 1'b0;
    localparam logic MODE_CROSSFADE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [LEVEL_W-1:0] level;
        logic [STEP_W-1:0]  step;
    } pbc_fade_cfg_t;

endpackage

### hdl/pbc_palette_mem.sv
module pbc_palette_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pbc_fade_unit.sv
module pbc_fade_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [pbc_pkg::INDEX_W-1:0]   in_index,
    input  logic                          in_inrange,
    input  logic [pbc_pkg::RGB_W-1:0]     src_rgb,
    input  logic [pbc_pkg::RGB_W-1:0]     tgt_rgb,
    input  pbc_pkg::pbc_fade_cfg_t        cfg,
    output logic                          out_valid,
    output logic [pbc_pkg::INDEX_W-1:0]   out_index,
    output logic [pbc_pkg::RGB_W-1:0]     out_rgb
);
    import pbc_pkg::*;

    logic               b_valid_reg, b_valid_next;
    logic [INDEX_W-1:0] b_index_reg;
    logic               b_mode_reg;
    logic [SUM_W-1:0]   b_sum_reg  [3];
    logic [SUM_W-1:0]   b_sum_next [3];

    logic               c_valid_reg, c_valid_next;
    logic [INDEX_W-1:0] c_index_reg;
    logic [RGB_W-1:0]   c_rgb_reg, c_rgb_next;

    logic [LEVEL_W-1:0] level_sat;
    logic [STEP_W-1:0]  step_inv;

    assign level_sat = (cfg.level > LEVEL_FULL) ? LEVEL_FULL : cfg.level;
    assign step_inv  = BLEND_FULL - cfg.step;

    always_comb
    begin
        logic [CHAN_W-1:0] s_ch;
        logic [CHAN_W-1:0] t_ch;
        for (int c = 0; c < 3; c++)
        begin
            s_ch = src_rgb[c*CHAN_W +: CHAN_W];
            t_ch = tgt_rgb[c*CHAN_W +: CHAN_W];
            if (!in_inrange)
            begin
                b_sum_next[c] = '0;
            end
            else if (cfg.mode == MODE_SCALE)
            begin
                b_sum_next[c] = SUM_W'(s_ch) * SUM_W'(level_sat);
            end
            else
            begin
                b_sum_next[c] = SUM_W'(s_ch) * SUM_W'(step_inv)
                              + SUM_W'(t_ch) * SUM_W'(cfg.step);
            end
        end
    end

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int c = 0; c < 3; c++)
        begin
            prod = PROD_W'(b_sum_reg[c]) * PROD_W'(RECIP);
            if (b_mode_reg == MODE_SCALE)
            begin
                c_rgb_next[c*CHAN_W +: CHAN_W] = b_sum_reg[c][LEVEL_SHIFT +: CHAN_W];
            end
            else
            begin
                c_rgb_next[c*CHAN_W +: CHAN_W] = prod[RECIP_SHIFT +: CHAN_W];
            end
        end
    end

    assign b_valid_next = adv ? in_valid : b_valid_reg;
    assign c_valid_next = adv ? b_valid_reg : c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_index_reg <= in_index;
            b_mode_reg  <= cfg.mode;
            for (int c = 0; c < 3; c++)
            begin
                b_sum_reg[c] <= b_sum_next[c];
            end
            c_index_reg <= b_index_reg;
            c_rgb_reg   <= c_rgb_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_index = c_index_reg;
    assign out_rgb   = c_rgb_reg;

    a_rise_from_b: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(c_valid_reg) |-> $past(b_valid_reg))
        else $error("output word without a product stage word");

    a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(b_valid_reg) && $stable(b_index_reg))
        else $error("product stage moved while stalled");

    a_hold_c: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && c_valid_reg) |=> $stable(c_rgb_reg) && $stable(c_index_reg))
        else $error("output colour changed while stalled");

endmodule

### hdl/palette_brightness_crossfade.sv
// channel   dir  fields (lowest bit up)                          accepted when
// s_axis    in   tuser: op; tdata: entry_index, red, green, blue  tvalid & tready
// m_axis    out  tdata: pixel_index, red, green, blue            tvalid & tready
// cfg       in   cfg_addr selects fade_mode, fade_level, blend_step   cfg_we
//
// One word a cycle while the output is not stalled. A lookup passes the
// palette read port, the product stage and the output stage (shift, or
// reciprocal divide by 31) before it appears. Writes go to the palettes in
// the cycle they are taken, so a later lookup always sees them. A stalled
// output holds the whole pipe and drops tready. Reset clears valid state and
// sets default configuration; palette contents are undefined until written.
module palette_brightness_crossfade #(
    parameter int ENTRIES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // entry_index, red, green, blue
    input  logic [pbc_pkg::OP_W-1:0]         s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // pixel_index, red, green, blue
    input  logic                             cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pbc_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic               adv;
    logic               accept;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] entry_index;
    logic [RGB_W-1:0]   wr_rgb;
    logic [ADDR_W-1:0]  addr;
    logic               inrange;
    logic               src_we, tgt_we, rd_en;
    logic [RGB_W-1:0]   src_q, tgt_q;

    logic               mode_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [STEP_W-1:0]  step_reg;
    pbc_fade_cfg_t      fade_cfg;

    logic               a_valid_reg, a_valid_next;
    logic [INDEX_W-1:0] a_index_reg;
    logic               a_inrange_reg;

    logic               out_valid;
    logic [INDEX_W-1:0] out_index;
    logic [RGB_W-1:0]   out_rgb;

    assign op          = s_axis_tuser;
    assign entry_index = s_axis_tdata[7:0];
    assign wr_rgb      = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
    assign addr        = ADDR_W'(entry_index);
    assign inrange     = 32'(entry_index) < ENTRIES;

    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    assign src_we = accept && (op == OP_WR_SRC) && inrange;
    assign tgt_we = accept && (op == OP_WR_TGT) && inrange;
    assign rd_en  = accept && (op == OP_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SCALE;
            level_reg <= LEVEL_FULL;
            step_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FADE_MODE:  mode_reg  <= cfg_wdata[0];
                CFG_FADE_LEVEL: level_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_BLEND_STEP: step_reg  <= cfg_wdata[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    assign fade_cfg.mode  = mode_reg;
    assign fade_cfg.level = level_reg;
    assign fade_cfg.step  = step_reg;

    pbc_palette_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W),
        .DATA_W (RGB_W)
    ) u_src_mem (
        .clk   (clk),
        .we    (src_we),
        .waddr (addr),
        .wdata (wr_rgb),
        .re    (rd_en),
        .raddr (addr),
        .rdata (src_q)
    );

    pbc_palette_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W),
        .DATA_W (RGB_W)
    ) u_tgt_mem (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (addr),
        .wdata (wr_rgb),
        .re    (rd_en),
        .raddr (addr),
        .rdata (tgt_q)
    );

    assign a_valid_next = adv ? rd_en : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            a_index_reg   <= entry_index;
            a_inrange_reg <= inrange;
        end
    end

    pbc_fade_unit u_fade (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (a_valid_reg),
        .in_index   (a_index_reg),
        .in_inrange (a_inrange_reg),
        .src_rgb    (src_q),
        .tgt_rgb    (tgt_q),
        .cfg        (fade_cfg),
        .out_valid  (out_valid),
        .out_index  (out_index),
        .out_rgb    (out_rgb)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_rgb[CHAN_W-1:0], out_rgb[2*CHAN_W-1:CHAN_W],
                            out_rgb[RGB_W-1:2*CHAN_W], out_index};

    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(src_we && tgt_we) && !(rd_en && (src_we || tgt_we)))
        else $error("palette written and read by one word");

    a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> a_valid_reg)
        else $error("lookup lost at the read stage");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !adv) |=> $stable(src_q) && $stable(tgt_q) && a_valid_reg)
        else $error("read data changed under a stall");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pbc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [INDEX_W-1:0] pix_index;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // palette shadow and fade settings
    logic [RGB_W-1:0]   src_pal [256];
    logic [RGB_W-1:0]   tgt_pal [256];
    bit                 src_written [256];
    bit                 tgt_written [256];
    bit                 listed [256];
    logic [INDEX_W-1:0] readable_idx [$];
    logic [INDEX_W-1:0] last_idx = '0;
    logic               fade_mode = MODE_SCALE;
    logic [LEVEL_W-1:0] fade_level = LEVEL_FULL;
    logic [STEP_W-1:0]  blend_step = '0;

    pixel_t pending_pixels [$];
    int     errors = 0;
    int     tx_stall_pct = 30;
    int     rx_stall_pct = 30;
    int     hold_ticket = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     rx_gap = 0;
    int     stuck = 0;

    palette_brightness_crossfade dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] src,
                                                   input logic [CHAN_W-1:0] tgt);
        int sv;
        int tv;
        int lv;
        int st;
        sv = int'(src);
        tv = int'(tgt);
        st = int'(blend_step);
        if (fade_mode == MODE_SCALE)
        begin
            lv = (fade_level > LEVEL_FULL) ? int'(LEVEL_FULL) : int'(fade_level);
            return CHAN_W'((sv * lv) >> LEVEL_SHIFT);
        end
        return CHAN_W'((sv * (int'(BLEND_FULL) - st) + tv * st) / int'(BLEND_FULL));
    endfunction

    function automatic pixel_t fade_colour(input logic [INDEX_W-1:0] idx);
        pixel_t p;
        p.pix_index = idx;
        p.red   = fade_chan(src_pal[idx][23:16], tgt_pal[idx][23:16]);
        p.green = fade_chan(src_pal[idx][15:8], tgt_pal[idx][15:8]);
        p.blue  = fade_chan(src_pal[idx][7:0], tgt_pal[idx][7:0]);
        return p;
    endfunction

    // apply one accepted word to the shadow palettes
    task automatic take_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [RGB_W-1:0] rgb);
        case (op)
            OP_WR_SRC:
            begin
                src_pal[idx] = rgb;
                src_written[idx] = 1'b1;
            end
            OP_WR_TGT:
            begin
                tgt_pal[idx] = rgb;
                tgt_written[idx] = 1'b1;
            end
            OP_LOOKUP: pending_pixels.push_back(fade_colour(idx));
            default: ;
        endcase
        if ((op == OP_WR_SRC || op == OP_WR_TGT) && src_written[idx] && tgt_written[idx])
        begin
            last_idx = idx;
            if (!listed[idx])
            begin
                listed[idx] = 1'b1;
                readable_idx.push_back(idx);
            end
        end
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [RGB_W-1:0] rgb);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_stall_pct)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        take_word(op, idx, rgb);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_fade(input logic [CFG_DATA_W-1:0] mode_v,
                            input logic [CFG_DATA_W-1:0] level_v,
                            input logic [CFG_DATA_W-1:0] step_v);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FADE_MODE;
        cfg_wdata <= mode_v;
        @(posedge clk);
        cfg_addr  <= CFG_FADE_LEVEL;
        cfg_wdata <= level_v;
        @(posedge clk);
        cfg_addr  <= CFG_BLEND_STEP;
        cfg_wdata <= step_v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        fade_mode  = mode_v[0];
        fade_level = level_v;
        blend_step = step_v[STEP_W-1:0];
    endtask

    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("unexpected pixel %h", got);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pix_index !== want.pix_index || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue)
        begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("pixel mismatch: expected idx %h rgb %h %h %h, got idx %h rgb %h %h %h",
                         want.pix_index, want.red, want.green, want.blue,
                         got.pix_index, got.red, got.green, got.blue);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel(pixel_t'(m_axis_tdata));
            if (hold_ticket != hold_seen)
            begin
                hold_seen     <= hold_ticket;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(99) < rx_stall_pct)
                    rx_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                stuck <= 0;
            else if (stuck >= STUCK_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
            else
                stuck <= stuck + 1;
        end
    end

    task automatic test_reset_defaults();
        send_word(OP_WR_SRC, 8'd0, 24'h000000);
        send_word(OP_WR_TGT, 8'd0, 24'hFFFFFF);
        send_word(OP_WR_SRC, 8'd255, 24'hFFFFFF);
        send_word(OP_WR_TGT, 8'd255, 24'h000000);
        send_word(OP_WR_SRC, 8'd1, 24'h807F01);
        send_word(OP_WR_TGT, 8'd1, 24'h01FE80);
        // unused op must leave entry 1 alone
        send_word(OP_UNUSED, 8'd1, RGB_W'($urandom));
        send_word(OP_LOOKUP, 8'd0, RGB_W'($urandom));
        send_word(OP_LOOKUP, 8'd255, RGB_W'($urandom));
        send_word(OP_LOOKUP, 8'd1, RGB_W'($urandom));
    endtask

    task automatic test_fade_extremes();
        logic [CFG_DATA_W-1:0] levels [5] = '{7'd0, 7'd1, 7'd63, 7'd65, 7'd127};
        logic [CFG_DATA_W-1:0] steps [4] = '{7'd0, 7'd1, 7'd30, 7'd31};
        foreach (levels[i])
        begin
            set_fade(7'(MODE_SCALE), levels[i], 7'($urandom_range(31)));
            send_word(OP_LOOKUP, 8'd255, RGB_W'($urandom));
            send_word(OP_LOOKUP, 8'd1, RGB_W'($urandom));
        end
        foreach (steps[i])
        begin
            set_fade(7'(MODE_CROSSFADE), 7'($urandom_range(127)), steps[i]);
            send_word(OP_LOOKUP, 8'd255, RGB_W'($urandom));
            send_word(OP_LOOKUP, 8'd1, RGB_W'($urandom));
        end
    endtask

    task automatic random_word();
        int pick;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 4)
            send_word(OP_UNUSED, INDEX_W'($urandom), RGB_W'($urandom));
        else if (pick < 52 && readable_idx.size() > 0)
        begin
            if ($urandom_range(3) == 0)
                idx = last_idx;
            else
                idx = readable_idx[$urandom_range(readable_idx.size() - 1)];
            send_word(OP_LOOKUP, idx, RGB_W'($urandom));
        end
        else
        begin
            idx = INDEX_W'($urandom);
            if ($urandom_range(15) == 0)
                idx = $urandom_range(1) ? 8'd255 : 8'd0;
            send_word($urandom_range(1) ? OP_WR_TGT : OP_WR_SRC, idx, RGB_W'($urandom));
        end
    endtask

    task automatic random_fade();
        logic [CFG_DATA_W-1:0] mode_v;
        logic [CFG_DATA_W-1:0] level_v;
        logic [CFG_DATA_W-1:0] step_v;
        mode_v = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(1));
        case ($urandom_range(4))
            0: level_v = 7'd0;
            1: level_v = LEVEL_FULL;
            2: level_v = 7'($urandom_range(127, 65));
            default: level_v = 7'($urandom_range(64));
        endcase
        case ($urandom_range(3))
            0: step_v = 7'd0;
            1: step_v = 7'(BLEND_FULL);
            2: step_v = 7'($urandom);
            default: step_v = 7'($urandom_range(31));
        endcase
        set_fade(mode_v, level_v, step_v);
    endtask

    task automatic test_random_traffic();
        int pcts [3] = '{0, 20, 50};
        repeat (6)
        begin
            random_fade();
            tx_stall_pct = pcts[$urandom_range(2)];
            rx_stall_pct <= pcts[$urandom_range(2)];
            repeat (190) random_word();
        end
    endtask

    task automatic test_output_hold();
        tx_stall_pct = 0;
        hold_ticket <= hold_ticket + 1;
        repeat (60) random_word();
        tx_stall_pct = 30;
    endtask

    task automatic test_sender_pause();
        rx_stall_pct <= 30;
        repeat (20) random_word();
        wait_drain();
        repeat (20) random_word();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_fade_extremes();
        test_random_traffic();
        test_output_hold();
        test_sender_pause();
        wait_drain();
        if (errors == 0 && pending_pixels.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### sim.f
hdl/pbc_pkg.sv
hdl/pbc_palette_mem.sv
hdl/pbc_fade_unit.sv
hdl/palette_brightness_crossfade.sv
sim/testbench.sv
